### hw/rtl/wcal_pkg.sv
package wcal_pkg;

	// Field widths of the clock and alarm counters, the set mode and the button latches.
	localparam int unsigned SEC_W  = 6;
	localparam int unsigned MIN_W  = 6;
	localparam int unsigned HOUR_W = 5;
	localparam int unsigned DAY_W  = 3;
	localparam int unsigned MODE_W = 3;
	localparam int unsigned ARM_W  = 3;

	// Last legal value of each field; the next step wraps to zero.
	localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
	localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
	localparam logic [DAY_W-1:0]  DAY_LAST  = 3'd6;

	// Relay switch-off offset in minutes, and the minute modulus.
	localparam logic [MIN_W:0] RELAY_OFF_MIN = 7'd10;
	localparam logic [MIN_W:0] MIN_MODULUS   = 7'd60;

	// Set mode codes.
	localparam logic [MODE_W-1:0] MODE_HOURS   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MINUTES = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SECONDS = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DAY     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ARMED   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd5;

	// Action codes of an input transaction.
	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_BUTTON = 1'b1;

	// Bit positions of the button release latches.
	localparam int unsigned ARM_PLUS     = 0;
	localparam int unsigned ARM_PLUS_TEN = 1;
	localparam int unsigned ARM_ADJUST   = 2;

	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [MIN_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
		logic [DAY_W-1:0]  day;
	} rtc_time_t;

	typedef struct packed {
		logic action;
		logic plus_level;
		logic plus_ten_level;
		logic adjust_level;
		logic edit_alarm;
	} wcal_item_t;

	typedef struct packed {
		rtc_time_t         now;
		rtc_time_t         alarm;
		logic [MODE_W-1:0] mode;
		logic [ARM_W-1:0]  armed;
		logic              relay;
	} wcal_state_t;

endpackage

### hw/rtl/wcal_next.sv
module wcal_next import wcal_pkg::*; (
	input  wcal_item_t  item,
	input  wcal_state_t cur,
	output wcal_state_t nxt
);

	// Add one or ten to the field that the mode selects, one to a weekday; past its limit it clears.
	function automatic rtc_time_t bump(input rtc_time_t t, input logic [MODE_W-1:0] mode,
			input logic by_ten);
		rtc_time_t          r;
		logic [HOUR_W:0]    h;
		logic [MIN_W:0]     m;
		logic [SEC_W:0]     s;
		logic [DAY_W:0]     d;
		r = t;
		h = {1'b0, t.hour} + (by_ten ? 6'd10 : 6'd1);
		m = {1'b0, t.min} + (by_ten ? 7'd10 : 7'd1);
		s = {1'b0, t.sec} + (by_ten ? 7'd10 : 7'd1);
		d = {1'b0, t.day} + 4'd1;
		case (mode)
			MODE_HOURS: begin
				r.hour = (h > {1'b0, HOUR_LAST}) ? '0 : h[HOUR_W-1:0];
			end
			MODE_MINUTES: begin
				r.min = (m > {1'b0, MIN_LAST}) ? '0 : m[MIN_W-1:0];
			end
			MODE_SECONDS: begin
				r.sec = (s > {1'b0, SEC_LAST}) ? '0 : s[SEC_W-1:0];
			end
			MODE_DAY: begin
				r.day = (d > {1'b0, DAY_LAST}) ? '0 : d[DAY_W-1:0];
			end
			default: begin
				r = t;
			end
		endcase
		return r;
	endfunction

	rtc_time_t          ticked;
	logic [ARM_W-1:0]   armed_set;
	logic               adj_fire;
	logic               plus_fire;
	logic               ten_fire;
	logic [MODE_W-1:0]  mode_n;
	logic [MIN_W:0]     off_sum;
	logic [MIN_W-1:0]   off_min;
	logic               match;
	rtc_time_t          sel;
	rtc_time_t          sel_plus;
	rtc_time_t          sel_ten;

	// One-second advance with ripple carry through the fields.
	always_comb begin
		ticked = cur.now;
		if (cur.now.sec >= SEC_LAST) begin
			ticked.sec = '0;
			if (cur.now.min >= MIN_LAST) begin
				ticked.min = '0;
				if (cur.now.hour >= HOUR_LAST) begin
					ticked.hour = '0;
					ticked.day  = (cur.now.day >= DAY_LAST) ? '0 : cur.now.day + 3'd1;
				end else begin
					ticked.hour = cur.now.hour + 5'd1;
				end
			end else begin
				ticked.min = cur.now.min + 6'd1;
			end
		end else begin
			ticked.sec = cur.now.sec + 6'd1;
		end
	end

	// Button presses latch; a later release fires the button once.
	always_comb begin
		armed_set = cur.armed;
		armed_set[ARM_PLUS]     = cur.armed[ARM_PLUS] | ~item.plus_level;
		armed_set[ARM_PLUS_TEN] = cur.armed[ARM_PLUS_TEN] | ~item.plus_ten_level;
		armed_set[ARM_ADJUST]   = cur.armed[ARM_ADJUST] | ~item.adjust_level;
		adj_fire  = item.adjust_level & armed_set[ARM_ADJUST];
		plus_fire = item.plus_level & armed_set[ARM_PLUS];
		ten_fire  = item.plus_ten_level & armed_set[ARM_PLUS_TEN];
		if (adj_fire) begin
			mode_n = (cur.mode >= MODE_IDLE) ? MODE_HOURS : cur.mode + 3'd1;
		end else begin
			mode_n = cur.mode;
		end
	end

	// Alarm match and the switch-off minute, both on the values before any edit.
	always_comb begin
		off_sum = {1'b0, cur.alarm.min} + RELAY_OFF_MIN;
		off_min = (off_sum >= MIN_MODULUS) ? 6'(off_sum - MIN_MODULUS)
			: off_sum[MIN_W-1:0];
		match   = (cur.now == cur.alarm);
	end

	// Field edits: plus first, then plus ten, on the side that edit_alarm picks.
	always_comb begin
		sel      = item.edit_alarm ? cur.alarm : cur.now;
		sel_plus = plus_fire ? bump(sel, mode_n, 1'b0) : sel;
		sel_ten  = ten_fire ? bump(sel_plus, mode_n, 1'b1) : sel_plus;
	end

	// Assemble the next state for either action.
	always_comb begin
		nxt = cur;
		if (item.action == ACT_TICK) begin
			nxt.now = ticked;
		end else begin
			nxt.mode  = mode_n;
			nxt.armed = armed_set & ~{adj_fire, ten_fire, plus_fire};
			if (mode_n == MODE_ARMED) begin
				if (cur.now.min == off_min) begin
					nxt.relay = 1'b0;
				end else if (match) begin
					nxt.relay = 1'b1;
				end
			end
			if (item.edit_alarm) begin
				nxt.alarm = sel_ten;
			end else begin
				nxt.now = sel_ten;
			end
		end
	end

endmodule

### hw/rtl/weekday_clock_with_alarm.sv
// Weekday clock with alarm relay.
// An accepted transaction is held in the input register, then its result in the state register.
// Throughput: one transaction per cycle while out_stall is low; the single state update per cycle sets this.
// Reset (arst_n low, asynchronous): clock, alarm, mode, button latches and relay
// clear to zero, and both pipeline stages empty.
module weekday_clock_with_alarm import wcal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic              plus_level,
	input  logic              plus_ten_level,
	input  logic              adjust_level,
	input  logic              edit_alarm,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SEC_W-1:0]  out_seconds,
	output logic [MIN_W-1:0]  out_minutes,
	output logic [HOUR_W-1:0] out_hours,
	output logic [DAY_W-1:0]  out_weekday,
	output logic [SEC_W-1:0]  out_alarm_seconds,
	output logic [MIN_W-1:0]  out_alarm_minutes,
	output logic [HOUR_W-1:0] out_alarm_hours,
	output logic [DAY_W-1:0]  out_alarm_weekday,
	output logic [MODE_W-1:0] set_mode,
	output logic              relay_on
);

	wcal_item_t  item_s1;
	logic        valid_s1;
	wcal_state_t state_q;
	wcal_state_t state_next;
	logic        out_valid_q;
	logic        advance;
	logic        accept;

	// The held item moves on whenever the result slot is empty or being drained.
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{action: action, plus_level: plus_level,
				plus_ten_level: plus_ten_level, adjust_level: adjust_level,
				edit_alarm: edit_alarm};
		end
	end

	wcal_next u_next (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_next)
	);

	// State register; it also holds the result shown on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_seconds       = state_q.now.sec;
	assign out_minutes       = state_q.now.min;
	assign out_hours         = state_q.now.hour;
	assign out_weekday       = state_q.now.day;
	assign out_alarm_seconds = state_q.alarm.sec;
	assign out_alarm_minutes = state_q.alarm.min;
	assign out_alarm_hours   = state_q.alarm.hour;
	assign out_alarm_weekday = state_q.alarm.day;
	assign set_mode          = state_q.mode;
	assign relay_on          = state_q.relay;

endmodule

### hw/rtl/wcal_checker.sv
module wcal_checker import wcal_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [SEC_W-1:0]  out_seconds,
	input logic [MIN_W-1:0]  out_minutes,
	input logic [HOUR_W-1:0] out_hours,
	input logic [DAY_W-1:0]  out_weekday,
	input logic [MODE_W-1:0] set_mode,
	input logic              relay_on
);

	// A stalled result keeps its seconds, minutes, set mode and relay.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_seconds) && $stable(out_minutes)
			&& $stable(set_mode) && $stable(relay_on))
		else $error("stalled result changed");

	// Clock fields stay inside their ranges.
	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_seconds <= SEC_LAST && out_minutes <= MIN_LAST
			&& out_hours <= HOUR_LAST && out_weekday <= DAY_LAST)
		else $error("clock field out of range");

	// Mode never steps past idle.
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		set_mode <= MODE_IDLE)
		else $error("set mode out of range");

	// The relay switches on only while the alarm is armed.
	a_relay_armed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(relay_on) |-> set_mode == MODE_ARMED)
		else $error("relay switched on outside armed mode");

	// Set mode and relay change only when a new result is delivered.
	a_state_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> $stable(set_mode) && $stable(relay_on) || out_valid)
		else $error("state changed without a result");

endmodule

bind weekday_clock_with_alarm wcal_checker u_wcal_checker (.*);

### tb/tb_weekday_clock_with_alarm.sv
module tb_weekday_clock_with_alarm;
	import wcal_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 20;
	localparam int BIG_STEP     = 10;

	typedef struct {
		wcal_item_t sample;
		bit         hold_for_drain;
	} pending_sample_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = ACT_TICK;
	logic              plus_level = 1'b1;
	logic              plus_ten_level = 1'b1;
	logic              adjust_level = 1'b1;
	logic              edit_alarm = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SEC_W-1:0]  out_seconds;
	logic [MIN_W-1:0]  out_minutes;
	logic [HOUR_W-1:0] out_hours;
	logic [DAY_W-1:0]  out_weekday;
	logic [SEC_W-1:0]  out_alarm_seconds;
	logic [MIN_W-1:0]  out_alarm_minutes;
	logic [HOUR_W-1:0] out_alarm_hours;
	logic [DAY_W-1:0]  out_alarm_weekday;
	logic [MODE_W-1:0] set_mode;
	logic              relay_on;

	pending_sample_t pending_items[$];
	wcal_state_t     expected_readings[$];
	wcal_state_t     planned_rtc;
	wcal_state_t     predicted_rtc;
	bit              drain_next;
	int              in_flight;
	int              idle_cycles;
	int              mismatch_count;
	int              burst_left;
	int              gap_left;
	stall_style_t    stall_style;
	int              style_left;

	weekday_clock_with_alarm dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.plus_level(plus_level),
		.plus_ten_level(plus_ten_level),
		.adjust_level(adjust_level),
		.edit_alarm(edit_alarm),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_seconds(out_seconds),
		.out_minutes(out_minutes),
		.out_hours(out_hours),
		.out_weekday(out_weekday),
		.out_alarm_seconds(out_alarm_seconds),
		.out_alarm_minutes(out_alarm_minutes),
		.out_alarm_hours(out_alarm_hours),
		.out_alarm_weekday(out_alarm_weekday),
		.set_mode(set_mode),
		.relay_on(relay_on)
	);

	always #CLK_HALF clk = ~clk;

	// Adds the given amount to the field that the set mode selects (the weekday by one); past its limit it clears.
	function automatic rtc_time_t bumped(rtc_time_t t, logic [MODE_W-1:0] m, int amount);
		int v;
		case (m)
			MODE_HOURS: begin
				v = t.hour + amount;
				t.hour = (v > HOUR_LAST) ? '0 : v[HOUR_W-1:0];
			end
			MODE_MINUTES: begin
				v = t.min + amount;
				t.min = (v > MIN_LAST) ? '0 : v[MIN_W-1:0];
			end
			MODE_SECONDS: begin
				v = t.sec + amount;
				t.sec = (v > SEC_LAST) ? '0 : v[SEC_W-1:0];
			end
			MODE_DAY: begin
				// The weekday always steps by one.
				v = t.day + 1;
				t.day = (v > DAY_LAST) ? '0 : v[DAY_W-1:0];
			end
			default: begin
			end
		endcase
		return t;
	endfunction

	// State of the clock after one transaction.
	function automatic wcal_state_t rtc_after(wcal_state_t s, wcal_item_t it);
		int        v;
		rtc_time_t edited;
		if (it.action == ACT_TICK) begin
			// A tick ripples through seconds, minutes, hours and weekday.
			v = s.now.sec + 1;
			if (v <= SEC_LAST) begin
				s.now.sec = v[SEC_W-1:0];
			end else begin
				s.now.sec = '0;
				v = s.now.min + 1;
				if (v <= MIN_LAST) begin
					s.now.min = v[MIN_W-1:0];
				end else begin
					s.now.min = '0;
					v = s.now.hour + 1;
					if (v <= HOUR_LAST) begin
						s.now.hour = v[HOUR_W-1:0];
					end else begin
						s.now.hour = '0;
						v = s.now.day + 1;
						s.now.day = (v > DAY_LAST) ? '0 : v[DAY_W-1:0];
					end
				end
			end
			return s;
		end
		// A pressed button arms its release latch.
		if (!it.plus_level) s.armed[ARM_PLUS] = 1'b1;
		if (!it.plus_ten_level) s.armed[ARM_PLUS_TEN] = 1'b1;
		if (!it.adjust_level) s.armed[ARM_ADJUST] = 1'b1;
		// Releasing adjust steps the set mode.
		if (it.adjust_level && s.armed[ARM_ADJUST]) begin
			s.armed[ARM_ADJUST] = 1'b0;
			v = s.mode + 1;
			s.mode = (v > MODE_IDLE) ? MODE_HOURS : v[MODE_W-1:0];
		end
		// The relay turns on at a full match and off ten minutes later.
		if (s.mode == MODE_ARMED) begin
			if (s.now == s.alarm) s.relay = 1'b1;
			v = (int'(s.alarm.min) + int'(RELAY_OFF_MIN)) % int'(MIN_MODULUS);
			if (s.now.min == v) s.relay = 1'b0;
		end
		// Releasing plus or plus-ten edits the clock or the alarm.
		edited = it.edit_alarm ? s.alarm : s.now;
		if (it.plus_level && s.armed[ARM_PLUS]) begin
			s.armed[ARM_PLUS] = 1'b0;
			edited = bumped(edited, s.mode, 1);
		end
		if (it.plus_ten_level && s.armed[ARM_PLUS_TEN]) begin
			s.armed[ARM_PLUS_TEN] = 1'b0;
			edited = bumped(edited, s.mode, BIG_STEP);
		end
		if (it.edit_alarm) s.alarm = edited;
		else s.now = edited;
		return s;
	endfunction

	function automatic int field_value(rtc_time_t t, logic [MODE_W-1:0] m);
		case (m)
			MODE_HOURS:   return t.hour;
			MODE_MINUTES: return t.min;
			MODE_SECONDS: return t.sec;
			MODE_DAY:     return t.day;
			default:      return 0;
		endcase
	endfunction

	// Queues a transaction and tracks where the sequence leaves the clock.
	task automatic push_item(wcal_item_t it);
		pending_sample_t p;
		p.sample = it;
		p.hold_for_drain = drain_next;
		drain_next = 1'b0;
		pending_items.push_back(p);
		planned_rtc = rtc_after(planned_rtc, it);
	endtask

	task automatic push_sample(logic [ARM_W-1:0] levels, bit ed);
		wcal_item_t it;
		it.action = ACT_BUTTON;
		it.plus_level = levels[ARM_PLUS];
		it.plus_ten_level = levels[ARM_PLUS_TEN];
		it.adjust_level = levels[ARM_ADJUST];
		it.edit_alarm = ed;
		push_item(it);
	endtask

	// Button levels and the edit select are random on a tick; they must not matter.
	task automatic push_tick();
		wcal_item_t it;
		it = wcal_item_t'(5'($urandom_range(0, 31)));
		it.action = ACT_TICK;
		push_item(it);
	endtask

	task automatic press_release(int arm_bit, bit ed);
		logic [ARM_W-1:0] levels;
		levels = '1;
		levels[arm_bit] = 1'b0;
		push_sample(levels, ed);
		push_sample('1, ed);
	endtask

	task automatic step_mode_to(logic [MODE_W-1:0] m);
		while (planned_rtc.mode != m) press_release(ARM_ADJUST, 1'($urandom_range(0, 1)));
	endtask

	// Walks one field to a target with the fewest button presses.
	task automatic set_field(bit ed, logic [MODE_W-1:0] m, int target);
		int cur;
		bit use_ten;
		forever begin
			step_mode_to(m);
			cur = field_value(ed ? planned_rtc.alarm : planned_rtc.now, m);
			if (cur == target) break;
			use_ten = (m != MODE_DAY) && (target < cur || target - cur >= BIG_STEP);
			press_release(use_ten ? ARM_PLUS_TEN : ARM_PLUS, ed);
		end
	endtask

	task automatic set_time(bit ed, rtc_time_t t);
		set_field(ed, MODE_HOURS, t.hour);
		set_field(ed, MODE_MINUTES, t.min);
		set_field(ed, MODE_SECONDS, t.sec);
		set_field(ed, MODE_DAY, t.day);
	endtask

	// Sets the clock just before a rollover and lets it tick through.
	task automatic run_rollover();
		rtc_time_t goal;
		goal.hour = $urandom_range(0, 1) ? HOUR_LAST : 5'($urandom_range(0, 23));
		goal.min = MIN_LAST;
		goal.sec = 6'($urandom_range(48, 59));
		goal.day = $urandom_range(0, 1) ? DAY_LAST : 3'($urandom_range(0, 6));
		push_sample('1, 1'($urandom_range(0, 1)));
		set_time(1'b0, goal);
		repeat ($urandom_range(12, 20)) push_tick();
	endtask

	// Brings clock and alarm together, arms the alarm, then moves the clock to the switch-off minute or lets it tick.
	task automatic run_alarm_hit();
		rtc_time_t goal;
		int        off_min;
		push_sample('1, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 1)) begin
			goal = planned_rtc.now;
			set_time(1'b1, goal);
		end else begin
			goal = planned_rtc.alarm;
			set_time(1'b0, goal);
		end
		step_mode_to(MODE_ARMED);
		repeat ($urandom_range(0, 2)) push_sample('1, 1'($urandom_range(0, 1)));
		off_min = (goal.min + BIG_STEP) % (MIN_LAST + 1);
		case ($urandom_range(0, 2))
			0: begin
				set_field(1'b0, MODE_MINUTES, off_min);
				step_mode_to(MODE_ARMED);
			end
			1: begin
				// Let the clock reach the switch-off minute on its own.
				set_field(1'b0, MODE_MINUTES, (off_min + MIN_LAST) % (MIN_LAST + 1));
				set_field(1'b0, MODE_SECONDS, $urandom_range(45, 59));
				step_mode_to(MODE_ARMED);
				repeat ($urandom_range(20, 90)) begin
					push_tick();
					if ($urandom_range(0, 2) == 0) push_sample('1, 1'($urandom_range(0, 1)));
				end
			end
			default: begin
				repeat ($urandom_range(1, 5)) push_tick();
			end
		endcase
	endtask

	// Stimulus plan, then reset, then wait for the last result.
	initial begin : stimulus
		int  pick;
		int  stop_at;
		bit  timed_out;
		planned_rtc = '0;
		drain_next = 1'b0;
		timed_out = 1'b0;

		// Directed opening: every button, both edit targets, limits and all modes.
		push_tick();
		push_sample('1, 1'b0);
		press_release(ARM_PLUS, 1'b0);
		press_release(ARM_PLUS_TEN, 1'b0);
		press_release(ARM_PLUS_TEN, 1'b1);
		// Plus and plus-ten held together, released together.
		push_sample(3'b100, 1'b0);
		push_sample('1, 1'b0);
		// Hours past their limit clear to zero.
		press_release(ARM_PLUS_TEN, 1'b0);
		step_mode_to(MODE_ARMED);
		push_sample('1, 1'b0);
		step_mode_to(MODE_IDLE);
		// A release in idle mode edits nothing.
		press_release(ARM_PLUS, 1'b1);
		step_mode_to(MODE_HOURS);

		// Random part: mostly well-formed sequences, some noise.
		stop_at = pending_items.size() + RANDOM_ITEMS;
		drain_next = 1'b1;
		while (pending_items.size() < stop_at) begin
			pick = $urandom_range(0, 19);
			if (pick <= 4) begin
				repeat ($urandom_range(1, 8))
					push_item(wcal_item_t'(5'($urandom_range(0, 31))));
			end else if (pick <= 8) begin
				repeat ($urandom_range(1, 60)) begin
					push_tick();
					if ($urandom_range(0, 7) == 0)
						push_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
				end
			end else if (pick <= 10) begin
				repeat ($urandom_range(1, 5)) begin
					push_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
					push_sample('1, 1'($urandom_range(0, 1)));
				end
			end else if (pick <= 12) begin
				repeat ($urandom_range(1, 7))
					press_release(ARM_ADJUST, 1'($urandom_range(0, 1)));
			end else if (pick <= 14) begin
				run_rollover();
			end else if (pick <= 17) begin
				run_alarm_hit();
			end else if (pick == 18) begin
				drain_next = 1'b1;
				repeat ($urandom_range(1, 4))
					push_item(wcal_item_t'(5'($urandom_range(0, 31))));
			end else begin
				// Broken sequence: a press, ticks in between, then a late release.
				push_sample(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 3)) push_tick();
				push_sample('1, 1'($urandom_range(0, 1)));
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (!timed_out &&
		       (pending_items.size() != 0 || in_valid || expected_readings.size() != 0)) begin
			@(negedge clk);
			if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
		end
		if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_readings.size() != 0)
			$error("%0d expected results never arrived", expected_readings.size());

		if (!timed_out && mismatch_count == 0 && expected_readings.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Driver: sends queued transactions in bursts with random gaps.
	always @(posedge clk or negedge arst_n) begin
		pending_sample_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_TICK;
			plus_level <= 1'b1;
			plus_ten_level <= 1'b1;
			adjust_level <= 1'b1;
			edit_alarm <= 1'b0;
			burst_left = $urandom_range(1, 24);
			gap_left = 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_items[0].hold_for_drain &&
			             (in_flight != 0 || in_valid)) begin
				// Hold off until every result in flight has come back.
				in_valid <= 1'b0;
			end else begin
				p = pending_items.pop_front();
				in_valid <= 1'b1;
				action <= p.sample.action;
				plus_level <= p.sample.plus_level;
				plus_ten_level <= p.sample.plus_ten_level;
				adjust_level <= p.sample.adjust_level;
				edit_alarm <= p.sample.edit_alarm;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Result stall pattern: runs of no stall, light, heavy and alternating stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_style = STALL_NONE;
			style_left = 0;
		end else begin
			if (style_left == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(20, 150);
			end else begin
				style_left--;
			end
			case (stall_style)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ~out_stall;
			endcase
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Monitor: predicts each accepted transaction and checks each result in order.
	always @(posedge clk or negedge arst_n) begin
		wcal_item_t  it;
		wcal_state_t want;
		bit          took_in;
		bit          took_out;
		if (!arst_n) begin
			predicted_rtc = '0;
			in_flight <= 0;
			idle_cycles <= 0;
		end else begin
			took_in = in_valid && !in_stall;
			took_out = out_valid && !out_stall;
			if (took_in) begin
				it.action = action;
				it.plus_level = plus_level;
				it.plus_ten_level = plus_ten_level;
				it.adjust_level = adjust_level;
				it.edit_alarm = edit_alarm;
				predicted_rtc = rtc_after(predicted_rtc, it);
				expected_readings.push_back(predicted_rtc);
			end
			if (took_out) begin
				if (expected_readings.size() == 0) begin
					$error("result transaction arrived with no expected result waiting");
					mismatch_count++;
				end else begin
					want = expected_readings.pop_front();
					check_field("out_seconds", want.now.sec, out_seconds);
					check_field("out_minutes", want.now.min, out_minutes);
					check_field("out_hours", want.now.hour, out_hours);
					check_field("out_weekday", want.now.day, out_weekday);
					check_field("out_alarm_seconds", want.alarm.sec, out_alarm_seconds);
					check_field("out_alarm_minutes", want.alarm.min, out_alarm_minutes);
					check_field("out_alarm_hours", want.alarm.hour, out_alarm_hours);
					check_field("out_alarm_weekday", want.alarm.day, out_alarm_weekday);
					check_field("set_mode", want.mode, set_mode);
					check_field("relay_on", want.relay, relay_on);
				end
			end
			in_flight <= in_flight + int'(took_in) - int'(took_out);
			idle_cycles <= (took_in || took_out) ? 0 : idle_cycles + 1;
		end
	end

endmodule
